@@ src/unique_ternary_code_generator_unit_defines.svh @@
// Assertion macros for the unique ternary code generator.
// Used by every file that carries concurrent assertions; needs clk and rst_n in scope.
`ifndef UNIQUE_TERNARY_CODE_GENERATOR_UNIT_DEFINES_SVH
`define UNIQUE_TERNARY_CODE_GENERATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define UTCG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UTCG_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define UTCG_ASSERT(lbl, prop, msg)
`define UTCG_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ src/utcg_pkg.sv @@
// Shared constants, types and helper functions of the unique ternary code generator.
// No dependencies; used by the interfaces, the RAM users and the top level.
package utcg_pkg;

    localparam int MAX_CODES   = 1024;
    localparam int MAX_TRITS   = 12;
    localparam int IDX_W       = $clog2(MAX_CODES);
    localparam int TOTAL_W     = $clog2(MAX_CODES + 1);
    localparam int WORD_W      = 2 * MAX_TRITS;
    localparam int TRIT_IDX_W  = $clog2(MAX_TRITS);
    localparam int LEN_W       = $clog2(MAX_TRITS + 1);
    localparam int COUNT_W     = 11;
    localparam int BITS_W      = 12;
    localparam int STATUS_W    = 2;
    localparam int INDEX_W     = 10;
    localparam int TRITS_W     = 24;
    localparam int VALUE_W     = 20;
    localparam int CMP_W       = (COUNT_W > TOTAL_W) ? COUNT_W : TOTAL_W;

    localparam int LIMIT_SHORT = 150;
    localparam int LIMIT_MID   = 850;
    localparam int LEN_SHORT   = 8;
    localparam int LEN_MID     = 10;
    localparam int LEN_LONG    = 12;

    typedef logic [WORD_W-1:0]     word_t;
    typedef logic [TOTAL_W-1:0]    total_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [TRIT_IDX_W-1:0] trit_idx_t;
    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [BITS_W-1:0]     bits_t;
    typedef logic [INDEX_W-1:0]    index_t;
    typedef logic [TRITS_W-1:0]    trits_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [CMP_W-1:0]      cmp_t;
    typedef logic [1:0]            trit_t;

    localparam trit_t TRIT_NONE = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_STORED = 2'd0,
        STATUS_DUP    = 2'd1,
        STATUS_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUILD,
        S_SCAN,
        S_DONE
    } state_t;

    // trit i sits at bits [2i+1:2i]
    function automatic word_t init_row();
        word_t w;
        w = '0;
        for (int i = 0; i < MAX_TRITS; i++)
        begin
            w[2*i +: 2] = trit_t'(i % 3);
        end
        return w;
    endfunction

    localparam word_t INIT_ROW = init_row();

    function automatic len_t word_len(input count_t count);
        int len;
        if (int'(count) <= LIMIT_SHORT)
        begin
            len = LEN_SHORT;
        end
        else if (int'(count) <= LIMIT_MID)
        begin
            len = LEN_MID;
        end
        else
        begin
            len = LEN_LONG;
        end
        if (len > MAX_TRITS)
        begin
            len = MAX_TRITS;
        end
        return len_t'(len);
    endfunction

    function automatic word_t trit_mask(input len_t len);
        word_t m;
        m = '0;
        for (int i = 0; i < MAX_TRITS; i++)
        begin
            if (i < int'(len))
            begin
                m[2*i +: 2] = 2'b11;
            end
        end
        return m;
    endfunction

    // lowest allowed value, or the second allowed value when two remain and pick is set
    function automatic trit_t pick_trit(input trit_t above, input trit_t left, input logic pick);
        logic [2:0] ok;
        trit_t      first;
        trit_t      second;
        ok[0] = (above != 2'd0) && (left != 2'd0);
        ok[1] = (above != 2'd1) && (left != 2'd1);
        ok[2] = (above != 2'd2) && (left != 2'd2);
        first  = ok[0] ? 2'd0 : (ok[1] ? 2'd1 : 2'd2);
        second = ok[2] ? 2'd2 : 2'd1;
        if (pick && ($countones(ok) == 2))
        begin
            return second;
        end
        return first;
    endfunction

endpackage

@@ src/utcg_if.sv @@
// Valid/ready channel interfaces for attempts and results.
// Depends on utcg_pkg for payload types.
interface utcg_attempt_if;
    logic             valid;
    logic             ready;
    utcg_pkg::bits_t  random_bits;

    modport source (output valid, output random_bits, input ready);
    modport sink   (input valid, input random_bits, output ready);
endinterface

interface utcg_result_if;
    logic               valid;
    logic               ready;
    utcg_pkg::status_t  status;
    utcg_pkg::index_t   code_index;
    utcg_pkg::trits_t   code_trits;
    utcg_pkg::value_t   code_value;

    modport source (output valid, output status, output code_index, output code_trits,
                    output code_value, input ready);
    modport sink   (input valid, input status, input code_index, input code_trits,
                    input code_value, output ready);
endinterface

@@ src/unique_ternary_code_generator_unit.sv @@
// Top level of the unique ternary code generator: sequencer, datapath and code table.
// Depends on utcg_pkg, utcg_if, utcg_ram and the assertion macro header.
//
// Usage:
//   attempt : valid/ready channel, one item carries random_bits for one attempt.
//   result  : valid/ready channel, one item per attempt (status, index, trits, value).
//   cfg     : cfg_wr_en/cfg_wr_data write code_count; write only while idle.
// An attempt is taken only when the block is idle. It builds the candidate one trit a
// cycle (8, 10 or 12 trits), then streams the stored words out of the code RAM one
// per cycle and compares each against the candidate (one read port sets this), stopping
// early on a match; a full table skips both steps and goes straight to the result.
// The result is then loaded into the output register, and the next attempt is taken
// only once the block is idle again, so no new attempt is taken before the last is done.
// After reset the table holds one word (0,1,2 repeating), code_count is 1024 and the
// block is idle at once: entry 0 is a constant, so no clearing pass is needed.
// A result waits in the output register while the receiver stalls; the block takes the
// next attempt meanwhile but holds its own result until the register frees.
`include "unique_ternary_code_generator_unit_defines.svh"

module unique_ternary_code_generator_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  utcg_pkg::count_t        cfg_wr_data,
    utcg_attempt_if.sink            attempt,
    utcg_result_if.source           result
);

    utcg_pkg::state_t    state_reg, state_next;
    utcg_pkg::count_t    count_reg;
    utcg_pkg::word_t     prev_reg;
    utcg_pkg::total_t    total_reg;
    utcg_pkg::trit_idx_t trit_idx_reg;
    utcg_pkg::len_t      len_reg;
    utcg_pkg::bits_t     bits_reg;
    utcg_pkg::word_t     cand_reg;
    utcg_pkg::trit_t     left_reg;
    utcg_pkg::trits_t    packed_reg;
    utcg_pkg::value_t    value_reg;
    utcg_pkg::total_t    rd_idx_reg;
    logic                rd_pend_reg;
    logic                first_reg;
    logic                dup_reg;
    logic                full_reg;

    logic                out_valid_reg;
    utcg_pkg::status_t   out_status_reg;
    utcg_pkg::index_t    out_index_reg;
    utcg_pkg::trits_t    out_trits_reg;
    utcg_pkg::value_t    out_value_reg;

    utcg_pkg::word_t     rd_data;
    utcg_pkg::word_t     mask;
    utcg_pkg::trit_t     above;
    utcg_pkg::trit_t     left;
    utcg_pkg::trit_t     trit;
    utcg_pkg::value_t    value_next;
    logic                last_trit;
    logic                is_full;
    logic                issue;
    logic                hit_mem;
    logic                hit_init;
    logic                scan_done;
    logic                attempt_ready;
    logic                load;
    logic                mem_we;
    logic                mem_re;

    assign mask       = utcg_pkg::trit_mask(len_reg);
    assign above      = prev_reg[2*trit_idx_reg +: 2];
    assign left       = (trit_idx_reg == '0) ? utcg_pkg::TRIT_NONE : left_reg;
    assign trit       = utcg_pkg::pick_trit(above, left, bits_reg[trit_idx_reg]);
    assign value_next = (value_reg << 1) + value_reg + utcg_pkg::value_t'(trit);
    assign last_trit  = (utcg_pkg::len_t'(trit_idx_reg) + utcg_pkg::len_t'(1)) == len_reg;

    assign is_full = (total_reg >= utcg_pkg::total_t'(utcg_pkg::MAX_CODES))
                  || (utcg_pkg::cmp_t'(total_reg) >= utcg_pkg::cmp_t'(count_reg));

    assign issue     = (rd_idx_reg < total_reg) && !dup_reg;
    assign hit_mem   = rd_pend_reg && (((rd_data ^ cand_reg) & mask) == '0);
    assign hit_init  = first_reg && (((utcg_pkg::INIT_ROW ^ cand_reg) & mask) == '0);
    assign scan_done = dup_reg || ((rd_idx_reg >= total_reg) && !rd_pend_reg && !first_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            utcg_pkg::S_IDLE:
            begin
                if (attempt.valid)
                begin
                    state_next = is_full ? utcg_pkg::S_DONE : utcg_pkg::S_BUILD;
                end
            end
            utcg_pkg::S_BUILD:
            begin
                if (last_trit)
                begin
                    state_next = utcg_pkg::S_SCAN;
                end
            end
            utcg_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = utcg_pkg::S_DONE;
                end
            end
            utcg_pkg::S_DONE:
            begin
                if (load)
                begin
                    state_next = utcg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = utcg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        attempt_ready = 1'b0;
        load          = 1'b0;
        mem_re        = 1'b0;
        case (state_reg)
            utcg_pkg::S_IDLE:
            begin
                attempt_ready = 1'b1;
            end
            utcg_pkg::S_SCAN:
            begin
                mem_re = issue;
            end
            utcg_pkg::S_DONE:
            begin
                load = !out_valid_reg || result.ready;
            end
            default:
            begin
                attempt_ready = 1'b0;
            end
        endcase
        mem_we = load && !full_reg && !dup_reg;
    end

    assign attempt.ready     = attempt_ready;
    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.code_index = out_index_reg;
    assign result.code_trits = out_trits_reg;
    assign result.code_value = out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= utcg_pkg::S_IDLE;
            count_reg     <= utcg_pkg::count_t'(utcg_pkg::MAX_CODES);
            prev_reg      <= utcg_pkg::INIT_ROW;
            total_reg     <= utcg_pkg::total_t'(1);
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            first_reg     <= 1'b0;
            dup_reg       <= 1'b0;
            full_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                utcg_pkg::S_IDLE:
                begin
                    if (attempt.valid)
                    begin
                        full_reg <= is_full;
                        dup_reg  <= 1'b0;
                    end
                end
                utcg_pkg::S_BUILD:
                begin
                    if (last_trit)
                    begin
                        first_reg   <= 1'b1;
                        rd_pend_reg <= 1'b0;
                        dup_reg     <= 1'b0;
                    end
                end
                utcg_pkg::S_SCAN:
                begin
                    first_reg   <= 1'b0;
                    rd_pend_reg <= issue;
                    dup_reg     <= dup_reg || hit_mem || hit_init;
                end
                utcg_pkg::S_DONE:
                begin
                    if (mem_we)
                    begin
                        prev_reg  <= (prev_reg & ~mask) | (cand_reg & mask);
                        total_reg <= total_reg + utcg_pkg::total_t'(1);
                    end
                end
                default:
                begin
                    first_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            utcg_pkg::S_IDLE:
            begin
                trit_idx_reg <= '0;
                len_reg      <= utcg_pkg::word_len(count_reg);
                bits_reg     <= attempt.random_bits;
                cand_reg     <= '0;
                packed_reg   <= '0;
                value_reg    <= '0;
            end
            utcg_pkg::S_BUILD:
            begin
                cand_reg[2*trit_idx_reg +: 2] <= trit;
                left_reg     <= trit;
                packed_reg   <= {packed_reg[utcg_pkg::TRITS_W-3:0], trit};
                value_reg    <= value_next;
                trit_idx_reg <= trit_idx_reg + utcg_pkg::trit_idx_t'(1);
                rd_idx_reg   <= utcg_pkg::total_t'(1);
            end
            utcg_pkg::S_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + utcg_pkg::total_t'(1);
                end
            end
            utcg_pkg::S_DONE:
            begin
                if (load)
                begin
                    if (full_reg)
                    begin
                        out_status_reg <= utcg_pkg::STATUS_FULL;
                        out_index_reg  <= '0;
                        out_trits_reg  <= '0;
                        out_value_reg  <= '0;
                    end
                    else
                    begin
                        out_status_reg <= dup_reg ? utcg_pkg::STATUS_DUP
                                                  : utcg_pkg::STATUS_STORED;
                        out_index_reg  <= dup_reg ? '0
                                                  : utcg_pkg::index_t'(total_reg);
                        out_trits_reg  <= packed_reg;
                        out_value_reg  <= value_reg;
                    end
                end
            end
            default:
            begin
                trit_idx_reg <= '0;
            end
        endcase
    end

    utcg_ram #(
        .WIDTH (utcg_pkg::WORD_W),
        .DEPTH (utcg_pkg::MAX_CODES)
    ) u_code_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (utcg_pkg::idx_t'(total_reg)),
        .wdata (cand_reg),
        .re    (mem_re),
        .raddr (utcg_pkg::idx_t'(rd_idx_reg)),
        .rdata (rd_data)
    );

    `UTCG_ASSERT(a_total_bound, total_reg <= utcg_pkg::total_t'(utcg_pkg::MAX_CODES), "stored total beyond table depth")
    `UTCG_ASSERT(a_store_room, mem_we |-> (total_reg < utcg_pkg::total_t'(utcg_pkg::MAX_CODES)), "store into a full table")
    `UTCG_ASSERT(a_total_step, mem_we |=> (total_reg == $past(total_reg) + utcg_pkg::total_t'(1)), "stored total did not advance")
    `UTCG_ASSERT(a_one_item, (attempt.valid && attempt.ready) |=> !attempt.ready, "second item taken while busy")
    `UTCG_ASSERT_NEVER(a_read_write, mem_re && mem_we, "code RAM read and written together")

endmodule

@@ src/utcg_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module utcg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
